// ===== rtl/scrt_pkg.sv =====
// Package of the set-associative row cache tag unit: geometry limits, widths,
// status and register codes, and the small cursor modulo function.
// Used by every module of the block except scrt_ram; depends on nothing.
package scrt_pkg;

  localparam int MAX_SETS  = 1024;
  localparam int MAX_WAYS  = 16;
  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int SCNT_W    = 11;
  localparam int WAY_W     = 4;
  localparam int WAYC_W    = 5;
  localparam int TAG_DEPTH = MAX_SETS * MAX_WAYS;
  localparam int SLOT_W    = $clog2(TAG_DEPTH);
  localparam int TAG_W     = 32;
  localparam int ID_W      = 32;
  localparam int ROW_W     = 31;
  localparam int CNT_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 31;
  localparam int OUT_PAY_W = SLOT_W + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  localparam int DIV_W      = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNCACHED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_ROW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OOB      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWNED_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWNED_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAY_COUNT  = 3'd4;

  localparam logic [WAYC_W-1:0] WAY_COUNT_RESET = 5'd4;

  // Remainder of a stored cursor by the ways in use, restoring style.
  function automatic logic [WAY_W-1:0] cur_mod(input logic [WAY_W-1:0] c,
                                                input logic [WAYC_W-1:0] d);
    logic [WAYC_W-1:0] r;
    r = '0;
    for (int i = WAY_W - 1; i >= 0; i--) begin
      r = {r[WAY_W-1:0], c[i]};
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[WAY_W-1:0];
  endfunction

endpackage

// ===== rtl/scrt_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Holds the tag store and the round-robin cursors; uses no package.
module scrt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/scrt_rem.sv =====
// Iterative remainder unit: row id modulo the set count, four bits per cycle.
// Depends on scrt_pkg for the widths and the step count.
module scrt_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [scrt_pkg::DIV_W-1:0]   dividend,
  input  logic [scrt_pkg::SCNT_W-1:0]  divisor,
  output logic                         done,
  output logic [scrt_pkg::SET_W-1:0]   remainder
);

  logic                              busy_r;
  logic                              done_r;
  logic [scrt_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [scrt_pkg::DIV_W-1:0]        dvd_r;
  logic [scrt_pkg::SCNT_W-1:0]       rem_r;
  logic [scrt_pkg::SCNT_W-1:0]       rem_nxt;
  logic [scrt_pkg::DIV_W-1:0]        dvd_nxt;

  always_comb begin
    logic [scrt_pkg::SCNT_W-1:0] r;
    logic [scrt_pkg::DIV_W-1:0]  q;
    r = rem_r;
    q = dvd_r;
    for (int i = 0; i < scrt_pkg::DIV_STEP; i++) begin
      r = {r[scrt_pkg::SCNT_W-2:0], q[scrt_pkg::DIV_W-1]};
      q = {q[scrt_pkg::DIV_W-2:0], 1'b0};
      if (r >= divisor) begin
        r = r - divisor;
      end
    end
    rem_nxt = r;
    dvd_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r &&
                (cnt_r == scrt_pkg::DIV_CNT_W'(scrt_pkg::DIV_CYCLES - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == scrt_pkg::DIV_CNT_W'(scrt_pkg::DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[scrt_pkg::SET_W-1:0];

endmodule

// ===== rtl/set_assoc_row_cache_tags_unit.sv =====
// Top level of the set-associative row cache tag unit with round-robin refill.
// Depends on scrt_pkg, scrt_ram (tag store, cursors) and scrt_rem (set modulo).
//
//   Channel | Direction | Handshake            | Payload
//   in_     | request   | in_tvalid/in_tready  | tdata: row_id
//   out_    | result    | out_tvalid/out_tready| tuser: status; tdata: slot, hit, miss
//   cfg_    | write     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One request at a time. Out of bounds and not owned ids go from the check straight
// to the result, and so does a lookup with caching off. A cached lookup first waits
// on the remainder unit, which runs eight four-bit steps, then makes one tag read per
// way through the single tag RAM port, up to the hitting way or through all ways in
// use on a miss. After reset a clearing pass empties the tags and cursors while
// in_tready is low; configuration writes are taken throughout.
// A new request is taken while a result waits; a stalled result holds the block
// in its final state until out_tready.
module set_assoc_row_cache_tags_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [scrt_pkg::ID_W-1:0]        in_tdata,   // [31:0] row_id
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [scrt_pkg::OUT_DATA_W-1:0]  out_tdata,  // [13:0] slot_index, [45:14] hit_total,
                                                       // [77:46] miss_total, [79:78] zero
  output logic [scrt_pkg::STATUS_W-1:0]    out_tuser,  // [2:0] status
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scrt_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_FILL  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  logic [scrt_pkg::ROW_W-1:0]   total_rows_r;
  logic [scrt_pkg::ROW_W-1:0]   owned_low_r;
  logic [scrt_pkg::ROW_W-1:0]   owned_high_r;
  logic [scrt_pkg::SCNT_W-1:0]  set_count_r;
  logic [scrt_pkg::WAYC_W-1:0]  way_count_r;

  logic [scrt_pkg::SCNT_W-1:0]  sets_eff;
  logic [scrt_pkg::WAYC_W-1:0]  ways_eff;

  logic [scrt_pkg::SLOT_W-1:0]  clr_cnt_r;
  logic [scrt_pkg::ID_W-1:0]    raw_r;
  logic [scrt_pkg::TAG_W-1:0]   tag_w;
  logic [scrt_pkg::SET_W-1:0]   set_r;
  logic [scrt_pkg::SLOT_W-1:0]  base_r;
  logic [scrt_pkg::WAYC_W-1:0]  issue_way_r;
  logic                         chk_vld_r;
  logic [scrt_pkg::WAY_W-1:0]   chk_way_r;
  logic [scrt_pkg::WAY_W-1:0]   cur_r;
  logic [scrt_pkg::WAYC_W-1:0]  cur_inc;
  logic [scrt_pkg::WAY_W-1:0]   cur_next;
  logic [scrt_pkg::STATUS_W-1:0] status_r;
  logic [scrt_pkg::SLOT_W-1:0]  slot_r;

  logic [scrt_pkg::CNT_W-1:0]   hit_r;
  logic [scrt_pkg::CNT_W-1:0]   miss_r;
  logic [scrt_pkg::CNT_W-1:0]   hit_nxt;
  logic [scrt_pkg::CNT_W-1:0]   miss_nxt;

  logic                          out_tvalid_r;
  logic [scrt_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [scrt_pkg::STATUS_W-1:0] out_tuser_r;

  logic                          in_fire;
  logic                          out_free;
  logic                          oob;
  logic                          not_owned;
  logic                          issue;
  logic                          tag_match;
  logic                          last_way;

  logic                          tag_rd_en;
  logic                          tag_wr_en;
  logic [scrt_pkg::SLOT_W-1:0]   tag_addr;
  logic [scrt_pkg::TAG_W-1:0]    tag_wdata;
  logic [scrt_pkg::TAG_W-1:0]    tag_rdata;
  logic                          cur_rd_en;
  logic                          cur_wr_en;
  logic [scrt_pkg::SET_W-1:0]    cur_addr;
  logic [scrt_pkg::WAY_W-1:0]    cur_wdata;
  logic [scrt_pkg::WAY_W-1:0]    cur_rdata;

  logic                          rem_start;
  logic                          rem_done;
  logic [scrt_pkg::SET_W-1:0]    rem_value;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    if (set_count_r > scrt_pkg::SCNT_W'(scrt_pkg::MAX_SETS)) begin
      sets_eff = scrt_pkg::SCNT_W'(scrt_pkg::MAX_SETS);
    end else begin
      sets_eff = set_count_r;
    end
    if (way_count_r == '0) begin
      ways_eff = scrt_pkg::WAYC_W'(1);
    end else if (way_count_r > scrt_pkg::WAYC_W'(scrt_pkg::MAX_WAYS)) begin
      ways_eff = scrt_pkg::WAYC_W'(scrt_pkg::MAX_WAYS);
    end else begin
      ways_eff = way_count_r;
    end
  end

  assign tag_w     = scrt_pkg::TAG_W'(raw_r[scrt_pkg::ROW_W-1:0]) + 1'b1;
  assign oob       = raw_r[scrt_pkg::ID_W-1] || (raw_r[scrt_pkg::ROW_W-1:0] >= total_rows_r);
  assign not_owned = (raw_r[scrt_pkg::ROW_W-1:0] < owned_low_r) ||
                     (raw_r[scrt_pkg::ROW_W-1:0] >= owned_high_r);
  assign issue     = (state_r == S_SCAN) && (issue_way_r < ways_eff);
  assign tag_match = chk_vld_r && (tag_rdata == tag_w);
  assign last_way  = ({1'b0, chk_way_r} == ways_eff - 1'b1);
  assign cur_inc   = {1'b0, cur_r} + 1'b1;
  assign cur_next  = (cur_inc == ways_eff) ? '0 : cur_inc[scrt_pkg::WAY_W-1:0];

  assign hit_nxt  = hit_r + scrt_pkg::CNT_W'(status_r == scrt_pkg::ST_HIT);
  assign miss_nxt = miss_r + scrt_pkg::CNT_W'((status_r == scrt_pkg::ST_MISS) ||
                                              (status_r == scrt_pkg::ST_UNCACHED));

  assign rem_start = (state_r == S_CHECK) && !oob && !not_owned && (set_count_r != '0);

  always_comb begin
    tag_rd_en = 1'b0;
    tag_wr_en = 1'b0;
    tag_addr  = base_r + scrt_pkg::SLOT_W'(issue_way_r);
    tag_wdata = tag_w;
    cur_rd_en = 1'b0;
    cur_wr_en = 1'b0;
    cur_addr  = set_r;
    cur_wdata = cur_next;
    unique case (state_r)
      S_CLEAR: begin
        tag_wr_en = 1'b1;
        tag_addr  = clr_cnt_r;
        tag_wdata = '0;
        cur_wr_en = 1'b1;
        cur_addr  = clr_cnt_r[scrt_pkg::SET_W-1:0];
        cur_wdata = '0;
      end
      S_MUL: begin
        cur_rd_en = 1'b1;
      end
      S_SCAN: begin
        tag_rd_en = issue;
      end
      S_FILL: begin
        tag_wr_en = 1'b1;
        tag_addr  = base_r + scrt_pkg::SLOT_W'(cur_r);
        cur_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == '1) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_CHECK;
      S_CHECK: state_nxt = rem_start ? S_DIV : S_DONE;
      S_DIV:   if (rem_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SCAN;
      S_SCAN: begin
        priority if (tag_match) begin
          state_nxt = S_DONE;
        end else if (chk_vld_r && last_way) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_FILL:  state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      total_rows_r <= '0;
      owned_low_r  <= '0;
      owned_high_r <= '0;
      set_count_r  <= '0;
      way_count_r  <= scrt_pkg::WAY_COUNT_RESET;
      hit_r        <= '0;
      miss_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          scrt_pkg::REG_TOTAL_ROWS: total_rows_r <= cfg_data;
          scrt_pkg::REG_OWNED_LOW:  owned_low_r  <= cfg_data;
          scrt_pkg::REG_OWNED_HIGH: owned_high_r <= cfg_data;
          scrt_pkg::REG_SET_COUNT:  set_count_r  <= cfg_data[scrt_pkg::SCNT_W-1:0];
          scrt_pkg::REG_WAY_COUNT:  way_count_r  <= cfg_data[scrt_pkg::WAYC_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
        hit_r        <= hit_nxt;
        miss_r       <= miss_nxt;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_r <= in_tdata;
    end
    if (state_r == S_CHECK) begin
      slot_r <= '0;
      priority if (oob) begin
        status_r <= scrt_pkg::ST_OOB;
      end else if (not_owned) begin
        status_r <= scrt_pkg::ST_ZERO_ROW;
      end else begin
        status_r <= scrt_pkg::ST_UNCACHED;
      end
    end
    if (state_r == S_DIV && rem_done) begin
      set_r <= rem_value;
    end
    if (state_r == S_MUL) begin
      base_r      <= scrt_pkg::SLOT_W'(set_r) * scrt_pkg::SLOT_W'(ways_eff);
      issue_way_r <= '0;
      chk_vld_r   <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      issue_way_r <= issue_way_r + scrt_pkg::WAYC_W'(issue);
      chk_vld_r   <= issue;
      chk_way_r   <= issue_way_r[scrt_pkg::WAY_W-1:0];
      cur_r       <= scrt_pkg::cur_mod(cur_rdata, ways_eff);
      if (tag_match) begin
        status_r <= scrt_pkg::ST_HIT;
        slot_r   <= base_r + scrt_pkg::SLOT_W'(chk_way_r);
      end
    end
    if (state_r == S_FILL) begin
      status_r <= scrt_pkg::ST_MISS;
      slot_r   <= base_r + scrt_pkg::SLOT_W'(cur_r);
    end
    if (state_r == S_DONE && out_free) begin
      out_tuser_r <= status_r;
      out_tdata_r <= {{(scrt_pkg::OUT_DATA_W - scrt_pkg::OUT_PAY_W){1'b0}},
                      miss_nxt, hit_nxt, slot_r};
    end
  end

  scrt_ram #(
    .DEPTH (scrt_pkg::TAG_DEPTH),
    .WIDTH (scrt_pkg::TAG_W)
  ) u_tag_ram (
    .clk   (clk),
    .rd_en (tag_rd_en),
    .wr_en (tag_wr_en),
    .addr  (tag_addr),
    .wdata (tag_wdata),
    .rdata (tag_rdata)
  );

  scrt_ram #(
    .DEPTH (scrt_pkg::MAX_SETS),
    .WIDTH (scrt_pkg::WAY_W)
  ) u_cur_ram (
    .clk   (clk),
    .rd_en (cur_rd_en),
    .wr_en (cur_wr_en),
    .addr  (cur_addr),
    .wdata (cur_wdata),
    .rdata (cur_rdata)
  );

  scrt_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  ({1'b0, raw_r[scrt_pkg::ROW_W-1:0]}),
    .divisor   (sets_eff),
    .done      (rem_done),
    .remainder (rem_value)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/scrt_checker.sv =====
// Port-level checker of the row cache tag unit, bound to the top level.
// Depends on scrt_pkg for widths and status codes.
module scrt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [scrt_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [scrt_pkg::STATUS_W-1:0]    out_tuser
);

  // A result that is not taken keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Results without a cache entry carry slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == scrt_pkg::ST_UNCACHED || out_tuser == scrt_pkg::ST_ZERO_ROW ||
                   out_tuser == scrt_pkg::ST_OOB)
    |-> out_tdata[scrt_pkg::SLOT_W-1:0] == '0)
    else $error("nonzero slot on an uncached result");

  // The clearing pass keeps requests out right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken during clearing pass");

  // One request at a time: a taken request closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

endmodule

bind set_assoc_row_cache_tags_unit scrt_checker u_scrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for set_assoc_row_cache_tags_unit: lookups are predicted by a
// behavioral copy of the tag store, cursors and counters, then checked result by result.
// Depends on scrt_pkg and the RTL of the block only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scrt_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam longint ROW_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    misses;
  } lookup_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
  } reg_write_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ID_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // Behavioral copy of the block's registers and state.
  logic [ROW_W-1:0]  m_total_rows;
  logic [ROW_W-1:0]  m_owned_low;
  logic [ROW_W-1:0]  m_owned_high;
  logic [SCNT_W-1:0] m_set_count;
  logic [WAYC_W-1:0] m_way_count;
  logic [TAG_W-1:0]  tag_copy [TAG_DEPTH];
  logic [WAY_W-1:0]  cursor_copy [MAX_SETS];
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  miss_cnt;

  lookup_result_t awaited_lookups [$];
  reg_write_t     reg_queue [$];

  logic [ID_W-1:0] win_base;
  int unsigned     win_span;
  bit              full_rate = 1'b0;
  int              hold_asks = 0;
  int              hold_seen;
  int              hold_left;
  int              rx_wait;
  int              errors = 0;
  int              results_seen = 0;
  int              rows_sent = 0;
  int              settings_applied = 0;
  int              status_tally [8];

  set_assoc_row_cache_tags_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40) begin
      $display("Mismatch at result %0d: %s is 0x%0h, predicted 0x%0h",
               results_seen, what, got, want);
    end
    errors++;
  endtask

  function automatic void clear_model();
    m_total_rows = '0;
    m_owned_low  = '0;
    m_owned_high = '0;
    m_set_count  = '0;
    m_way_count  = WAY_COUNT_RESET;
    hit_cnt      = '0;
    miss_cnt     = '0;
    for (int i = 0; i < TAG_DEPTH; i++) tag_copy[i] = '0;
    for (int i = 0; i < MAX_SETS; i++) cursor_copy[i] = '0;
    for (int i = 0; i < 8; i++) status_tally[i] = 0;
  endfunction

  function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
    case (idx)
      REG_TOTAL_ROWS: m_total_rows = val;
      REG_OWNED_LOW:  m_owned_low  = val;
      REG_OWNED_HIGH: m_owned_high = val;
      REG_SET_COUNT:  m_set_count  = val[SCNT_W-1:0];
      REG_WAY_COUNT:  m_way_count  = val[WAYC_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [ID_W-1:0] row);
    lookup_result_t r;
    int unsigned sets, ways, set_no, base, way, victim;
    logic [TAG_W-1:0] tag;
    r = '0;
    tag = row + 32'd1;
    if (row[ID_W-1] || row >= ID_W'(m_total_rows)) begin
      r.status = ST_OOB;
    end else if (row < ID_W'(m_owned_low) || row >= ID_W'(m_owned_high)) begin
      r.status = ST_ZERO_ROW;
    end else if (m_set_count == '0) begin
      miss_cnt++;
      r.status = ST_UNCACHED;
    end else begin
      sets = (m_set_count > MAX_SETS) ? MAX_SETS : int'(m_set_count);
      if (m_way_count == '0) begin
        ways = 1;
      end else begin
        ways = (m_way_count > MAX_WAYS) ? MAX_WAYS : int'(m_way_count);
      end
      set_no = row % sets;
      base = set_no * ways;
      way = 0;
      while (way < ways && tag_copy[base + way] != tag) way++;
      if (way < ways) begin
        hit_cnt++;
        r.status = ST_HIT;
        r.slot = SLOT_W'(base + way);
      end else begin
        victim = cursor_copy[set_no] % ways;
        cursor_copy[set_no] = WAY_W'((victim + 1) % ways);
        tag_copy[base + victim] = tag;
        miss_cnt++;
        r.status = ST_MISS;
        r.slot = SLOT_W'(base + victim);
      end
    end
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    status_tally[r.status]++;
    return r;
  endfunction

  // Every result is compared with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    lookup_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      results_seen++;
      if (awaited_lookups.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'(out_tuser), '0);
      end else begin
        want = awaited_lookups.pop_front();
        if (out_tuser !== want.status) begin
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        end
        if (out_tdata[SLOT_W-1:0] !== want.slot) begin
          report_mismatch("slot_index", 32'(out_tdata[SLOT_W-1:0]), 32'(want.slot));
        end
        if (out_tdata[SLOT_W +: CNT_W] !== want.hits) begin
          report_mismatch("hit_total", out_tdata[SLOT_W +: CNT_W], want.hits);
        end
        if (out_tdata[SLOT_W+CNT_W +: CNT_W] !== want.misses) begin
          report_mismatch("miss_total", out_tdata[SLOT_W+CNT_W +: CNT_W], want.misses);
        end
      end
    end
  end

  // Unless full_rate is set, the receiver stalls each result for a random number of
  // cycles, and holds off completely for a long stretch whenever a test asks for it.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      hold_left = 0;
      hold_seen = 0;
      out_tready <= 1'b0;
    end else begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (out_tvalid === 1'b1 && out_tready) begin
        rx_wait = full_rate ? 0 : $urandom_range(0, 4);
      end else if (rx_wait > 0 && out_tvalid === 1'b1) begin
        rx_wait--;
      end
      if (hold_left > 0) hold_left--;
      out_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  task automatic send_row(input logic [ID_W-1:0] row);
    int unsigned gap;
    gap = full_rate ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= row;
    do @(posedge clk); while (in_tready !== 1'b1);
    awaited_lookups.push_back(predict_lookup(row));
    rows_sent++;
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk);
  endtask

  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    reg_queue.push_back(w);
  endfunction

  task automatic commit_regs();
    reg_write_t w;
    while (reg_queue.size() > 0) begin
      w = reg_queue.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.val;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      model_write(w.idx, w.val);
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [ID_W-1:0] pick_row();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return win_base + ID_W'($urandom_range(0, win_span));
    if (roll < 87) return $urandom;
    case ($urandom_range(0, 7))
      0: return ID_W'(m_owned_low) - 32'd1;
      1: return ID_W'(m_owned_low);
      2: return ID_W'(m_owned_high) - 32'd1;
      3: return ID_W'(m_owned_high);
      4: return ID_W'(m_total_rows) - 32'd1;
      5: return ID_W'(m_total_rows);
      6: return 32'h8000_0000 | ID_W'($urandom_range(0, 255));
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Draws bounds, an owned range and a geometry, and a small window of row ids
  // around the owned range so that lookups repeat and hit.
  function automatic void random_setting();
    longint lo, hi, tot;
    logic [SCNT_W-1:0] sets;
    logic [WAYC_W-1:0] ways;
    logic [CFG_W-1:0] junk;
    case ($urandom_range(0, 4))
      0: begin
        lo = 0;
        hi = ROW_MAX;
        tot = ROW_MAX;
      end
      1: begin
        lo = $urandom_range(0, 4096);
        hi = lo + $urandom_range(64, 4096);
        tot = hi - 32 + $urandom_range(0, 64);
      end
      2: begin
        hi = ROW_MAX;
        lo = hi - $urandom_range(64, 5000);
        tot = ROW_MAX;
      end
      3: begin
        lo = $urandom & ROW_MAX;
        hi = lo + $urandom_range(64, 100000);
        if (hi > ROW_MAX) hi = ROW_MAX;
        tot = $urandom_range(0, 1) ? ROW_MAX : hi;
      end
      default: begin
        lo = $urandom_range(100, 5000);
        hi = lo - $urandom_range(0, 50);
        tot = lo + 100;
      end
    endcase
    win_span = $urandom_range(2, 48);
    case ($urandom_range(0, 3))
      0: win_base = ID_W'(lo - win_span / 2);
      1: win_base = ID_W'(hi - win_span / 2);
      default: begin
        if (hi > lo + win_span) begin
          win_base = ID_W'(lo + $urandom_range(0, 32'(hi - lo - win_span)));
        end else begin
          win_base = ID_W'(lo);
        end
      end
    endcase
    case ($urandom_range(0, 7))
      0: sets = '0;
      1: sets = SCNT_W'(1);
      2: sets = SCNT_W'($urandom_range(2, 8));
      3: sets = SCNT_W'($urandom_range(9, 200));
      4: sets = SCNT_W'(MAX_SETS);
      5: sets = SCNT_W'($urandom_range(MAX_SETS + 1, 2047));
      default: sets = SCNT_W'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 5))
      0: ways = '0;
      1: ways = WAYC_W'(1);
      2: ways = WAYC_W'(MAX_WAYS);
      3: ways = WAYC_W'($urandom_range(MAX_WAYS + 1, 31));
      default: ways = WAYC_W'($urandom_range(2, MAX_WAYS - 1));
    endcase
    set_reg(REG_TOTAL_ROWS, CFG_W'(tot));
    set_reg(REG_OWNED_LOW, CFG_W'(lo));
    set_reg(REG_OWNED_HIGH, CFG_W'(hi));
    junk = $urandom_range(0, 1) ? CFG_W'($urandom) : '0;
    if ($urandom_range(0, 4) != 0) set_reg(REG_SET_COUNT, {junk[CFG_W-1:SCNT_W], sets});
    junk = $urandom_range(0, 1) ? CFG_W'($urandom) : '0;
    if ($urandom_range(0, 4) != 0) set_reg(REG_WAY_COUNT, {junk[CFG_W-1:WAYC_W], ways});
    if ($urandom_range(0, 5) == 0) begin
      set_reg(CFG_IDX_W'(REG_WAY_COUNT + $urandom_range(1, 3)), CFG_W'($urandom));
    end
  endfunction

  // With the registers at reset the table is empty, so every id is out of bounds.
  task automatic test_out_of_bounds();
    send_row(32'h0000_0000);
    send_row(32'h7FFF_FFFF);
    send_row(32'h8000_0000);
    send_row(32'hFFFF_FFFF);
    wait_results();
  endtask

  // The way count is left at its reset value of four while set 0 fills and evicts.
  task automatic test_default_ways_eviction();
    set_reg(REG_TOTAL_ROWS, 31'h7FFF_FFFF);
    set_reg(REG_OWNED_LOW, 31'd16);
    set_reg(REG_OWNED_HIGH, 31'h7FFF_FFFF);
    set_reg(REG_SET_COUNT, 31'd2);
    commit_regs();
    send_row(32'd15);
    send_row(32'h7FFF_FFFF);
    send_row(32'd16);
    send_row(32'd18);
    send_row(32'd20);
    send_row(32'd22);
    send_row(32'd18);
    send_row(32'd24);
    send_row(32'd16);
    send_row(32'h7FFF_FFFE);
    wait_results();
  endtask

  // Oversized set and way counts are clamped, an empty owned range owns nothing,
  // and a row cached under the old geometry misses under the new one.
  task automatic test_geometry_limits();
    set_reg(REG_SET_COUNT, 31'd2047);
    set_reg(REG_WAY_COUNT, 31'd31);
    set_reg(REG_OWNED_LOW, 31'd500);
    set_reg(REG_OWNED_HIGH, 31'd500);
    commit_regs();
    send_row(32'd500);
    wait_results();
    set_reg(REG_OWNED_LOW, 31'd0);
    set_reg(REG_OWNED_HIGH, 31'h7FFF_FFFF);
    commit_regs();
    send_row(32'd1023);
    send_row(32'd2047);
    send_row(32'd1023);
    send_row(32'd24);
    wait_results();
  endtask

  // With caching off every lookup misses; a way count of zero behaves as one way.
  task automatic test_uncached_single_way();
    set_reg(REG_SET_COUNT, 31'd0);
    set_reg(REG_WAY_COUNT, 31'd0);
    commit_regs();
    send_row(32'd5);
    wait_results();
    set_reg(REG_SET_COUNT, 31'd1);
    commit_regs();
    send_row(32'd7);
    send_row(32'd7);
    send_row(32'd8);
    send_row(32'd7);
    wait_results();
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      random_setting();
      commit_regs();
      repeat (per_phase) send_row(pick_row());
      wait_results();
    end
  endtask

  // The receiver holds off while requests keep coming, so the block fills and
  // stops taking requests until the hold is over.
  task automatic test_result_backpressure();
    random_setting();
    commit_regs();
    hold_asks++;
    repeat (16) send_row(pick_row());
    wait_results();
  endtask

  task automatic test_sender_pause();
    random_setting();
    commit_regs();
    repeat (3) begin
      repeat (15) send_row(pick_row());
      wait_results();
    end
  endtask

  task automatic test_full_rate();
    full_rate = 1'b1;
    random_setting();
    commit_regs();
    repeat (120) send_row(pick_row());
    wait_results();
    full_rate = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    clear_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_out_of_bounds();
    test_default_ways_eviction();
    test_geometry_limits();
    test_uncached_single_way();
    test_random_settings(13, 100);
    test_result_backpressure();
    test_sender_pause();
    test_full_rate();

    wait_results();
    repeat (40) @(posedge clk);
    if (awaited_lookups.size() != 0) begin
      report_mismatch("requests without a result", 32'(awaited_lookups.size()), '0);
    end
    $display("Covered %0d lookups over %0d register settings, with one %0d-cycle result hold.",
             rows_sent, settings_applied, HOLD_CYCLES);
    $display("Outcomes: %0d hits, %0d fills, %0d uncached, %0d zero-row, %0d out of bounds.",
             status_tally[ST_HIT], status_tally[ST_MISS], status_tally[ST_UNCACHED],
             status_tally[ST_ZERO_ROW], status_tally[ST_OOB]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
